// ===== design/srpt_pkg.sv =====
// Shared constants, types and codes for the shortest-remaining-time tick scheduler.
package srpt_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_CMP_W = 7;

    localparam int SLOT_W = 6;
    localparam int TIME_W = 16;
    localparam int SUM_W = 24;
    localparam int UNIT_W = SUM_W + 1;

    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 104;

    localparam logic [TIME_W-1:0] TIME_LIMIT_RESET = 16'd100;
    localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;
    localparam logic [SUM_W-1:0] SUM_MAX = 24'hFFFFFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DEC,
        ST_COMP,
        ST_TURN,
        ST_WAIT,
        ST_SUMW,
        ST_SUMT,
        ST_EMIT,
        ST_TIME
    } t_state;

endpackage

// ===== design/srpt_tick_scheduler.sv =====
// Top level of the shortest-remaining-time tick scheduler with its sequencer and shared adder.
//
// Usage:
//   Input stream (s_axis): tuser carries the op (0 = load slot, 1 = tick), tdata
//   carries slot, arrival and burst. A load writes the slot table in the cycle of
//   its transfer and the block is ready again in the next cycle. A tick scans all
//   NUM_SLOTS entries with one comparator, one entry per cycle, then runs every
//   arithmetic step (decrement, completion, turnaround, waiting, two saturating
//   sums, time advance) through a single 25-bit add/subtract unit.
//   Without a completion a tick runs the scan, the decrement and the time advance;
//   with one it adds the completion steps and the emit step before the time advance.
//   A tick past time_limit is dropped in its transfer cycle.
//   Output stream (m_axis): one transfer per completed task, held in an output
//   register. If the receiver stalls, the block still finishes the current tick up
//   to the emit step and waits there until the register frees up.
//   Config channel: cfg_data writes time_limit; always ready.
//   Reset (synchronous, active low): clears the tables, time, sums, output valid,
//   and sets time_limit to 100.
module srpt_tick_scheduler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: slot[5:0], arrival[21:6], burst[37:22], zero fill to 40 bits
    input  logic [srpt_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: op[0]
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: done_slot[5:0], finish_tick[21:6], wait_ticks[37:22],
    //        turn_ticks[53:38], total_waiting[77:54], total_turnaround[101:78],
    //        zero fill to 104 bits
    output logic [srpt_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [srpt_pkg::TIME_W-1:0]        i_cfg_data
);

    localparam int TW = srpt_pkg::TIME_W;
    localparam int SW = srpt_pkg::SUM_W;
    localparam int IW = srpt_pkg::SLOT_IDX_W;
    localparam int NS = srpt_pkg::NUM_SLOTS;

    srpt_pkg::t_state r_state, n_state;

    // Slot tables, read at the scan index only
    logic [TW-1:0] r_arr [NS];
    logic [TW-1:0] r_bur [NS];
    logic [TW-1:0] r_rem [NS];

    logic [TW-1:0] r_limit;
    logic [TW-1:0] r_time;
    logic [SW-1:0] r_wsum;
    logic [SW-1:0] r_tsum;

    // Scan state and the best candidate so far
    logic [IW-1:0] r_idx;
    logic          r_found;
    logic [IW-1:0] r_pick;
    logic [TW-1:0] r_best_rem;
    logic [TW-1:0] r_best_arr;
    logic [TW-1:0] r_best_bur;

    // Results of the completion steps
    logic [TW-1:0] r_comp;
    logic [TW-1:0] r_turn;
    logic [TW-1:0] r_wait;

    logic                             r_out_valid;
    logic [srpt_pkg::OUT_DATA_W-1:0]  r_out_data;

    // Input fields
    logic [srpt_pkg::SLOT_W-1:0] w_in_slot;
    logic [TW-1:0]               w_in_arr;
    logic [TW-1:0]               w_in_bur;
    logic                        w_in_accept;
    logic                        w_load_ok;

    // Shared add/subtract unit
    logic [SW-1:0]               w_ua;
    logic [SW-1:0]               w_ub;
    logic                        w_usub;
    logic [srpt_pkg::UNIT_W-1:0] w_usum;
    logic [TW-1:0]               w_sat16;
    logic [SW-1:0]               w_sat24;

    logic [TW-1:0] w_rd_arr;
    logic [TW-1:0] w_rd_bur;
    logic [TW-1:0] w_rd_rem;
    logic          w_elig;
    logic          w_scan_last;
    logic          w_out_free;

    assign w_in_slot = i_s_axis_tdata[5:0];
    assign w_in_arr  = i_s_axis_tdata[21:6];
    assign w_in_bur  = i_s_axis_tdata[37:22];

    assign o_s_axis_tready = (r_state == srpt_pkg::ST_IDLE);
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load_ok       = ({1'b0, w_in_slot} < srpt_pkg::SLOT_CMP_W'(NS));

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign w_rd_arr    = r_arr[r_idx];
    assign w_rd_bur    = r_bur[r_idx];
    assign w_rd_rem    = r_rem[r_idx];
    assign w_scan_last = (r_idx == IW'(NS - 1));
    assign w_elig      = (w_rd_arr <= r_time) && (w_rd_rem != '0) &&
                         (!r_found || (w_rd_rem < r_best_rem));

    // Operand selection for the shared unit
    always_comb begin
        w_ua   = '0;
        w_ub   = '0;
        w_usub = 1'b0;
        case (r_state)
            srpt_pkg::ST_DEC: begin
                w_ua   = SW'(r_best_rem);
                w_ub   = SW'(1);
                w_usub = 1'b1;
            end
            srpt_pkg::ST_COMP, srpt_pkg::ST_TIME: begin
                w_ua = SW'(r_time);
                w_ub = SW'(1);
            end
            srpt_pkg::ST_TURN: begin
                w_ua   = SW'(r_comp);
                w_ub   = SW'(r_best_arr);
                w_usub = 1'b1;
            end
            srpt_pkg::ST_WAIT: begin
                w_ua   = SW'(r_turn);
                w_ub   = SW'(r_best_bur);
                w_usub = 1'b1;
            end
            srpt_pkg::ST_SUMW: begin
                w_ua = r_wsum;
                w_ub = SW'(r_wait);
            end
            srpt_pkg::ST_SUMT: begin
                w_ua = r_tsum;
                w_ub = SW'(r_turn);
            end
            default: begin
                w_ua = '0;
            end
        endcase
    end

    // For a subtract, bit 24 set means a borrow; for an add it is the 24-bit carry
    assign w_usum  = {1'b0, w_ua} + ({1'b0, w_ub} ^ {srpt_pkg::UNIT_W{w_usub}}) +
                     srpt_pkg::UNIT_W'(w_usub);
    assign w_sat16 = w_usum[TW] ? srpt_pkg::TIME_MAX : w_usum[TW-1:0];
    assign w_sat24 = w_usum[SW] ? srpt_pkg::SUM_MAX : w_usum[SW-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srpt_pkg::ST_IDLE: begin
                if (w_in_accept && (i_s_axis_tuser == srpt_pkg::OP_TICK) &&
                    (r_time <= r_limit)) begin
                    n_state = srpt_pkg::ST_SCAN;
                end
            end
            srpt_pkg::ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = srpt_pkg::ST_DEC;
                end
            end
            srpt_pkg::ST_DEC: begin
                if (r_found && (w_usum[TW-1:0] == '0)) begin
                    n_state = srpt_pkg::ST_COMP;
                end else begin
                    n_state = srpt_pkg::ST_TIME;
                end
            end
            srpt_pkg::ST_COMP: n_state = srpt_pkg::ST_TURN;
            srpt_pkg::ST_TURN: n_state = srpt_pkg::ST_WAIT;
            srpt_pkg::ST_WAIT: n_state = srpt_pkg::ST_SUMW;
            srpt_pkg::ST_SUMW: n_state = srpt_pkg::ST_SUMT;
            srpt_pkg::ST_SUMT: n_state = srpt_pkg::ST_EMIT;
            srpt_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = srpt_pkg::ST_TIME;
                end
            end
            srpt_pkg::ST_TIME: n_state = srpt_pkg::ST_IDLE;
            default: n_state = srpt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= srpt_pkg::TIME_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // Slot tables: load writes a whole slot, the decrement step writes remaining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_arr[k] <= '0;
                r_bur[k] <= '0;
                r_rem[k] <= '0;
            end
        end else if (w_in_accept && (i_s_axis_tuser == srpt_pkg::OP_LOAD) && w_load_ok) begin
            r_arr[w_in_slot[IW-1:0]] <= w_in_arr;
            r_bur[w_in_slot[IW-1:0]] <= w_in_bur;
            r_rem[w_in_slot[IW-1:0]] <= w_in_bur;
        end else if ((r_state == srpt_pkg::ST_DEC) && r_found) begin
            r_rem[r_pick] <= w_usum[TW-1:0];
        end
    end

    // Time and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_wsum <= '0;
            r_tsum <= '0;
        end else begin
            case (r_state)
                srpt_pkg::ST_TIME: r_time <= w_sat16;
                srpt_pkg::ST_SUMW: r_wsum <= w_sat24;
                srpt_pkg::ST_SUMT: r_tsum <= w_sat24;
                default: begin
                    r_time <= r_time;
                end
            endcase
        end
    end

    // Scan bookkeeping and completion arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            case (r_state)
                srpt_pkg::ST_IDLE: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                end
                srpt_pkg::ST_SCAN: begin
                    if (!w_scan_last) begin
                        r_idx <= r_idx + IW'(1);
                    end
                    if (w_elig) begin
                        r_found <= 1'b1;
                    end
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            srpt_pkg::ST_SCAN: begin
                if (w_elig) begin
                    r_pick     <= r_idx;
                    r_best_rem <= w_rd_rem;
                    r_best_arr <= w_rd_arr;
                    r_best_bur <= w_rd_bur;
                end
            end
            srpt_pkg::ST_COMP: r_comp <= w_sat16;
            srpt_pkg::ST_TURN: r_turn <= w_usum[TW-1:0];
            // Clamp at zero on borrow
            srpt_pkg::ST_WAIT: r_wait <= w_usum[SW] ? '0 : w_usum[TW-1:0];
            default: begin
                r_comp <= r_comp;
            end
        endcase
    end

    // Output register: hold until the receiver takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == srpt_pkg::ST_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == srpt_pkg::ST_EMIT) && w_out_free) begin
            r_out_data <= {2'b00, r_tsum, r_wsum, r_turn, r_wait, r_comp,
                           srpt_pkg::SLOT_W'(r_pick)};
        end
    end

endmodule

// ===== design/srpt_checker.sv =====
// Port-level checker for the shortest-remaining-time tick scheduler, bound to the top level.
module srpt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [srpt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    // A held result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // A load never blocks the input side
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == srpt_pkg::OP_LOAD)
        |=> o_s_axis_tready)
        else $error("load did not return to ready");

    // A new result is only produced while a tick is being worked on
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result appeared outside a tick");

    // Running totals include the current item and saturate above any single time
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[101:78] >= 24'(o_m_axis_tdata[53:38])) &&
                            (o_m_axis_tdata[77:54] >= 24'(o_m_axis_tdata[37:22])))
        else $error("running total below current item");

endmodule

bind srpt_tick_scheduler srpt_checker u_srpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the shortest-remaining-time tick scheduler.
module testbench;

    // One load or tick command and one completion report.
    typedef struct {
        logic                        op;
        logic [srpt_pkg::SLOT_W-1:0] slot;
        logic [srpt_pkg::TIME_W-1:0] arrival;
        logic [srpt_pkg::TIME_W-1:0] burst;
    } t_job_cmd;

    typedef struct {
        logic [srpt_pkg::SLOT_W-1:0] slot;
        logic [srpt_pkg::TIME_W-1:0] completion;
        logic [srpt_pkg::TIME_W-1:0] waited;
        logic [srpt_pkg::TIME_W-1:0] turnaround;
        logic [srpt_pkg::SUM_W-1:0]  wait_total;
        logic [srpt_pkg::SUM_W-1:0]  turn_total;
    } t_job_done;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [srpt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                            i_s_axis_tuser = 1'b0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [srpt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [srpt_pkg::TIME_W-1:0]     i_cfg_data = '0;

    srpt_tick_scheduler u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial forever #1 i_clk = ~i_clk;

    // Scheduler shadow state, advanced at each accepted transfer.
    logic [srpt_pkg::TIME_W-1:0] arr_mem   [srpt_pkg::NUM_SLOTS] = '{default: '0};
    logic [srpt_pkg::TIME_W-1:0] burst_mem [srpt_pkg::NUM_SLOTS] = '{default: '0};
    logic [srpt_pkg::TIME_W-1:0] rem_mem   [srpt_pkg::NUM_SLOTS] = '{default: '0};
    logic [srpt_pkg::TIME_W-1:0] sched_now = '0;
    logic [srpt_pkg::TIME_W-1:0] lim_now = srpt_pkg::TIME_LIMIT_RESET;
    logic [srpt_pkg::SUM_W-1:0]  wait_sum = '0;
    logic [srpt_pkg::SUM_W-1:0]  turn_sum = '0;

    t_job_cmd                    cmd_q[$];
    t_job_done                   done_q[$];
    logic [srpt_pkg::TIME_W-1:0] limit_q[$];
    t_job_cmd                    drv_cmd;
    t_job_done                   exp_done;

    int src_idle_pct = 20;
    int snk_idle_pct = 82;
    int n_err = 0;
    int n_load = 0;
    int n_tick_run = 0;
    int n_tick_idle = 0;
    int n_tick_drop = 0;
    int n_done = 0;

    // Generator-side view of time, so arrivals land near the live window.
    logic [srpt_pkg::TIME_W-1:0] plan_now = '0;
    logic [srpt_pkg::TIME_W-1:0] plan_limit = srpt_pkg::TIME_LIMIT_RESET;

    // Apply one command to the shadow state; queue a completion when one results.
    task automatic srpt_advance(input t_job_cmd c);
        int        pick;
        bit        found;
        t_job_done d;
        logic [srpt_pkg::TIME_W-1:0] comp;
        logic [srpt_pkg::TIME_W-1:0] turn;
        logic [srpt_pkg::TIME_W-1:0] wt;
        logic [srpt_pkg::SUM_W:0]    s;
        pick = 0;
        found = 0;
        if (c.op == srpt_pkg::OP_LOAD) begin
            n_load++;
            if (int'(c.slot) < srpt_pkg::NUM_SLOTS) begin
                arr_mem[c.slot[srpt_pkg::SLOT_IDX_W-1:0]] = c.arrival;
                burst_mem[c.slot[srpt_pkg::SLOT_IDX_W-1:0]] = c.burst;
                rem_mem[c.slot[srpt_pkg::SLOT_IDX_W-1:0]] = c.burst;
            end
            return;
        end
        if (sched_now > lim_now) begin
            n_tick_drop++;
            return;
        end
        for (int k = 0; k < srpt_pkg::NUM_SLOTS; k++) begin
            if (arr_mem[k] <= sched_now && rem_mem[k] != '0 &&
                (!found || rem_mem[k] < rem_mem[pick])) begin
                pick = k;
                found = 1;
            end
        end
        if (found) begin
            n_tick_run++;
            rem_mem[pick] = rem_mem[pick] - 1'b1;
            if (rem_mem[pick] == '0) begin
                comp = (sched_now == srpt_pkg::TIME_MAX) ? srpt_pkg::TIME_MAX :
                       sched_now + 1'b1;
                turn = comp - arr_mem[pick];
                wt = (turn > burst_mem[pick]) ? turn - burst_mem[pick] : '0;
                s = {1'b0, wait_sum} + (srpt_pkg::SUM_W + 1)'(wt);
                wait_sum = s[srpt_pkg::SUM_W] ? srpt_pkg::SUM_MAX : s[srpt_pkg::SUM_W-1:0];
                s = {1'b0, turn_sum} + (srpt_pkg::SUM_W + 1)'(turn);
                turn_sum = s[srpt_pkg::SUM_W] ? srpt_pkg::SUM_MAX : s[srpt_pkg::SUM_W-1:0];
                d.slot = srpt_pkg::SLOT_W'(pick);
                d.completion = comp;
                d.waited = wt;
                d.turnaround = turn;
                d.wait_total = wait_sum;
                d.turn_total = turn_sum;
                done_q.push_back(d);
                n_done++;
            end
        end else begin
            n_tick_idle++;
        end
        if (sched_now != srpt_pkg::TIME_MAX) sched_now = sched_now + 1'b1;
    endtask

    function automatic void check_field(string name, logic [63:0] exp_v,
                                        logic [63:0] got_v);
        if (exp_v != got_v) begin
            n_err++;
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        end
    endfunction

    // Command driver: hold tvalid until the transfer, idle at random between items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                srpt_advance(drv_cmd);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    drv_cmd = cmd_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser <= drv_cmd.op;
                    i_s_axis_tdata <= {2'b00, drv_cmd.burst, drv_cmd.arrival, drv_cmd.slot};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Limit register writer; the shadow limit follows each config transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                lim_now = i_cfg_data;
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (limit_q.size() != 0) begin
                    i_cfg_valid <= 1'b1;
                    i_cfg_data <= limit_q.pop_front();
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Completion monitor: compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (done_q.size() == 0) begin
                    n_err++;
                    $error("completion transfer with nothing expected");
                end else begin
                    exp_done = done_q.pop_front();
                    check_field("done_slot", 64'(exp_done.slot), 64'(o_m_axis_tdata[5:0]));
                    check_field("finish_tick", 64'(exp_done.completion),
                                64'(o_m_axis_tdata[21:6]));
                    check_field("wait_ticks", 64'(exp_done.waited),
                                64'(o_m_axis_tdata[37:22]));
                    check_field("turn_ticks", 64'(exp_done.turnaround),
                                64'(o_m_axis_tdata[53:38]));
                    check_field("total_waiting", 64'(exp_done.wait_total),
                                64'(o_m_axis_tdata[77:54]));
                    check_field("total_turnaround", 64'(exp_done.turn_total),
                                64'(o_m_axis_tdata[101:78]));
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Queue one command and track where time will stand once it runs.
    task automatic push_cmd(input logic op, input logic [srpt_pkg::SLOT_W-1:0] slot,
                            input logic [srpt_pkg::TIME_W-1:0] arrival,
                            input logic [srpt_pkg::TIME_W-1:0] burst);
        t_job_cmd c;
        c.op = op;
        c.slot = slot;
        c.arrival = arrival;
        c.burst = burst;
        cmd_q.push_back(c);
        if (op == srpt_pkg::OP_TICK && plan_now <= plan_limit &&
            plan_now != srpt_pkg::TIME_MAX)
            plan_now = plan_now + 1'b1;
    endtask

    // Wait until every command is taken and every completion is in, then let
    // a possibly running no-result tick finish.
    task automatic drain();
        while (cmd_q.size() != 0 || i_s_axis_tvalid || done_q.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Write the limit while idle and resync the generator's view of time.
    task automatic set_limit(input logic [srpt_pkg::TIME_W-1:0] value);
        limit_q.push_back(value);
        @(negedge i_clk);
        while (limit_q.size() != 0 || i_cfg_valid) @(negedge i_clk);
        plan_limit = value;
        plan_now = sched_now;
    endtask

    // Random tick with junk in the ignored fields.
    task automatic push_tick();
        push_cmd(srpt_pkg::OP_TICK, srpt_pkg::SLOT_W'($urandom),
                 srpt_pkg::TIME_W'($urandom), srpt_pkg::TIME_W'($urandom));
    endtask

    // Mostly well-formed work: loads into live slots with small bursts near the
    // current time, and ticks to run them; the rest is noise loads.
    task automatic push_mix(input int n);
        int r;
        logic [srpt_pkg::TIME_W-1:0] arr;
        logic [srpt_pkg::TIME_W-1:0] bur;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 22) begin
                if ($urandom_range(3) == 0) arr = srpt_pkg::TIME_W'($urandom_range(plan_now));
                else arr = plan_now + srpt_pkg::TIME_W'($urandom_range(4));
                r = $urandom_range(99);
                if (r < 8) bur = '0;
                else if (r < 75) bur = srpt_pkg::TIME_W'($urandom_range(6, 1));
                else if (r < 95) bur = srpt_pkg::TIME_W'($urandom_range(40, 7));
                else bur = srpt_pkg::TIME_W'($urandom);
                push_cmd(srpt_pkg::OP_LOAD,
                         srpt_pkg::SLOT_W'($urandom_range(srpt_pkg::NUM_SLOTS - 1)), arr, bur);
            end else if (r < 27) begin
                push_cmd(srpt_pkg::OP_LOAD,
                         srpt_pkg::SLOT_W'($urandom_range(63, srpt_pkg::NUM_SLOTS)),
                         srpt_pkg::TIME_W'($urandom), srpt_pkg::TIME_W'($urandom));
            end else if (r < 30) begin
                push_cmd(srpt_pkg::OP_LOAD,
                         srpt_pkg::SLOT_W'($urandom_range(srpt_pkg::NUM_SLOTS - 1)),
                         srpt_pkg::TIME_W'($urandom), srpt_pkg::TIME_W'($urandom));
            end else begin
                push_tick();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: tie on equal remaining time, out-of-range slots, zero burst,
        // preemption by a later shorter task, reload of a running slot, idle ticks.
        push_cmd(srpt_pkg::OP_LOAD, 6'd0, 16'd0, 16'd3);
        push_cmd(srpt_pkg::OP_LOAD, 6'd1, 16'd0, 16'd3);
        push_cmd(srpt_pkg::OP_LOAD, 6'd5, 16'd0, 16'd1);
        push_cmd(srpt_pkg::OP_LOAD, 6'd63, 16'hFFFF, 16'hFFFF);
        push_cmd(srpt_pkg::OP_LOAD, 6'd2, 16'd0, 16'd0);
        push_cmd(srpt_pkg::OP_LOAD, 6'd3, 16'd2, 16'd1);
        push_cmd(srpt_pkg::OP_TICK, 6'h3F, 16'hFFFF, 16'hFFFF);
        repeat (4) push_cmd(srpt_pkg::OP_TICK, 6'd0, 16'd0, 16'd0);
        push_cmd(srpt_pkg::OP_LOAD, 6'd1, 16'd0, 16'd2);
        repeat (4) push_tick();
        push_cmd(srpt_pkg::OP_LOAD, 6'd3, 16'hFFFF, 16'hFFFF);
        drain();

        // Limit at zero: ticks drop without advancing time.
        set_limit(16'd0);
        push_cmd(srpt_pkg::OP_TICK, 6'd0, 16'd0, 16'd0);
        push_cmd(srpt_pkg::OP_LOAD, 6'd0, 16'd0, 16'd1);
        push_cmd(srpt_pkg::OP_TICK, 6'd0, 16'd0, 16'd0);
        drain();

        // Limit equal to the current time: one tick runs, the next drops.
        set_limit(sched_now);
        repeat (3) push_cmd(srpt_pkg::OP_TICK, 6'd0, 16'd0, 16'd0);
        drain();

        // Random, slow receiver; pause once mid-phase until all results are in.
        set_limit(16'd1000);
        push_mix(320);
        drain();
        push_mix(320);
        drain();

        // Random, slow sender.
        src_idle_pct = 82;
        snk_idle_pct = 20;
        set_limit(srpt_pkg::TIME_MAX - 1'b1);
        push_mix(640);
        drain();

        // No idling: random work back to back.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        push_mix(640);
        drain();
        repeat (10) @(negedge i_clk);

        $display("Covered %0d loads and %0d ticks: %0d scheduled, %0d idle, %0d past the limit.",
                 n_load, n_tick_run + n_tick_idle + n_tick_drop, n_tick_run, n_tick_idle,
                 n_tick_drop);
        $display("Checked %0d completions; final time %0d, totals %0d waiting, %0d turnaround.",
                 n_done, sched_now, wait_sum, turn_sum);
        if (n_err == 0 && done_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #1000000;
        $display("Timed out with %0d commands and %0d completions outstanding.",
                 cmd_q.size(), done_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
